[hdl/bpc_pkg.sv]
package bpc_pkg;

    // tag widths through the dividers; the pressure tag rides in the low bits
    localparam int DivTagW   = 54;
    localparam int PressTagW = 19;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_cal;

    // floor shift on a 32-bit signed word
    function automatic logic signed [31:0] asr32(input logic signed [31:0] v,
                                                 input int unsigned n);
        asr32 = v >>> n;
    endfunction

endpackage

[hdl/bpc_div.sv]
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
// Unsigned 32/32 quotient; tag carries side data alongside.
module bpc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [31:0]                 i_num,
    input  logic [31:0]                 i_den,
    input  logic [bpc_pkg::DivTagW-1:0] i_tag,
    output logic                        o_valid,
    output logic [31:0]                 o_quo,
    output logic [bpc_pkg::DivTagW-1:0] o_tag
);
    logic                        r_v   [32];
    logic [31:0]                 r_n   [32];
    logic [31:0]                 r_d   [32];
    logic [31:0]                 r_rem [32];
    logic [bpc_pkg::DivTagW-1:0] r_t   [32];

    for (genvar k = 0; k < 32; k++) begin : g_st
        logic                        w_v;
        logic [31:0]                 w_n;
        logic [31:0]                 w_d;
        logic [31:0]                 w_rem;
        logic [bpc_pkg::DivTagW-1:0] w_t;
        logic [33:0]                 n_try;
        logic [32:0]                 n_sh;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_n   = i_num;
            assign w_d   = i_den;
            assign w_rem = '0;
            assign w_t   = i_tag;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_n   = r_n[k-1];
            assign w_d   = r_d[k-1];
            assign w_rem = r_rem[k-1];
            assign w_t   = r_t[k-1];
        end

        always_comb begin
            n_sh  = {w_rem, w_n[31]};
            n_try = {1'b0, n_sh} - {2'b0, w_d};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
            if (i_en) begin
                r_d[k] <= w_d;
                r_t[k] <= w_t;
                if (!n_try[33]) begin
                    r_rem[k] <= n_try[31:0];
                    r_n[k]   <= {w_n[30:0], 1'b1};
                end else begin
                    r_rem[k] <= n_sh[31:0];
                    r_n[k]   <= {w_n[30:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[31];
    assign o_quo   = r_n[31];
    assign o_tag   = r_t[31];
endmodule

[hdl/bpc_temp.sv]
// Temperature path: X1, signed X2 divide, B5.
module bpc_temp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [15:0]        i_ut,
    input  logic [18:0]        i_up,
    input  bpc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output logic signed [31:0] o_b5,
    output logic [18:0]        o_up,
    output logic               o_err
);
    logic               r_v1;
    logic signed [31:0] r_prod;
    logic [18:0]        r_up1;
    logic               r_v2;
    logic signed [31:0] r_x1;
    logic signed [31:0] r_den;
    logic [18:0]        r_up2;

    logic signed [31:0]          n_diff;
    logic signed [31:0]          n_x1;
    logic signed [31:0]          n_num;
    logic [31:0]                 n_anum;
    logic [31:0]                 n_aden;
    logic [bpc_pkg::DivTagW-1:0] n_tag;
    logic                        w_dv;
    logic [31:0]                 w_q;
    logic [bpc_pkg::DivTagW-1:0] w_tag;
    logic signed [31:0]          w_x2;
    logic signed [31:0]          w_x1;
    logic [31:0]                 w_qmag;

    always_comb begin
        n_diff = $signed({16'd0, i_ut}) - $signed({16'd0, i_cal.ac6});
        n_x1   = bpc_pkg::asr32(r_prod, 15);
        n_num  = 32'(i_cal.mc) <<< 11;
        n_anum = n_num[31] ? 32'(-n_num) : n_num;
        n_aden = r_den[31] ? 32'(-r_den) : r_den;
        n_tag  = {r_x1, r_up2, n_num[31] ^ r_den[31], r_den == 32'sd0, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_prod <= 32'(n_diff * $signed({16'd0, i_cal.ac5}));
            r_up1  <= i_up;
            r_x1   <= n_x1;
            r_den  <= 32'(n_x1 + 32'(i_cal.md));
            r_up2  <= r_up1;
        end
    end

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v2),
        .i_num   (n_anum),
        .i_den   (n_aden),
        .i_tag   (n_tag),
        .o_valid (w_dv),
        .o_quo   (w_q),
        .o_tag   (w_tag)
    );

    always_comb begin
        w_qmag = w_q;
        w_x2   = w_tag[2] ? 32'(-w_qmag) : $signed(w_qmag);
        w_x1   = $signed(w_tag[bpc_pkg::DivTagW-1 -: 32]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_dv;
        end
        if (i_en) begin
            o_b5  <= 32'(w_x1 + w_x2);
            o_up  <= w_tag[bpc_pkg::DivTagW-33 -: 19];
            o_err <= w_tag[1];
        end
    end
endmodule

[hdl/bpc_press.sv]
// Pressure path: temperature tenths, B6, B3, B4, B7, unsigned divide, final correction.
module bpc_press (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_b5,
    input  logic [18:0]        i_up,
    input  logic               i_err,
    input  bpc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output logic signed [15:0] o_temp,
    output logic [19:0]        o_press,
    output logic               o_err
);
    // stage A
    logic r_va; logic signed [31:0] r_b6, r_b6sq, r_ac2b6, r_ac3b6; logic [18:0] r_upa;
    logic signed [15:0] r_ta; logic r_ea;
    // stage B
    logic r_vb; logic signed [31:0] r_sq, r_ac2b6b, r_ac3b6b; logic [18:0] r_upb;
    logic signed [15:0] r_tb; logic r_eb;
    // stage C
    logic r_vc; logic signed [31:0] r_b2sq, r_b1sq, r_ac2b6c, r_ac3b6c; logic [18:0] r_upc;
    logic signed [15:0] r_tc; logic r_ec;
    // stage D
    logic r_vd; logic signed [31:0] r_b3; logic [31:0] r_x3p; logic [18:0] r_upd;
    logic signed [15:0] r_td; logic r_ed;
    // stage E
    logic r_ve; logic [31:0] r_b4; logic [31:0] r_updiff; logic signed [15:0] r_te; logic r_ee;
    // stage F
    logic r_vf; logic [31:0] r_b4f; logic [31:0] r_b7; logic signed [15:0] r_tf; logic r_ef;

    logic signed [31:0] n_t, n_x3a, n_b3pre, n_x3b, n_sh;
    logic signed [15:0] n_tsat;
    logic [47:0]        n_b4w;
    logic               n_hi;
    logic [31:0]        n_num;
    logic [bpc_pkg::PressTagW-1:0] n_tag;
    logic [bpc_pkg::DivTagW-1:0]   n_dtag;

    always_comb begin
        n_t    = bpc_pkg::asr32(32'(i_b5 + 32'sd8), 4);
        n_tsat = (n_t > 32'sd32767) ? 16'sh7fff :
                 (n_t < -32'sd32768) ? 16'sh8000 : n_t[15:0];
        n_x3a  = 32'(bpc_pkg::asr32(r_b2sq, 11) + bpc_pkg::asr32(r_ac2b6c, 11));
        n_sh   = 32'(32'(32'(r_vc ? 32'(i_cal.ac1) <<< 2 : 32'(i_cal.ac1) <<< 2) + n_x3a)
                 << i_cal.oss);
        n_b3pre = 32'(n_sh + 32'sd2);
        n_x3b  = bpc_pkg::asr32(32'(32'(bpc_pkg::asr32(r_ac3b6c, 13)
                 + bpc_pkg::asr32(r_b1sq, 16)) + 32'sd2), 2);
        n_b4w  = 48'(r_x3p) * 48'(i_cal.ac4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0;
            r_vd <= 1'b0; r_ve <= 1'b0; r_vf <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid; r_vb <= r_va; r_vc <= r_vb;
            r_vd <= r_vc; r_ve <= r_vd; r_vf <= r_ve;
        end
        if (i_en) begin
            r_b6    <= 32'(i_b5 - 32'sd4000);
            r_b6sq  <= 32'(32'(i_b5 - 32'sd4000) * 32'(i_b5 - 32'sd4000));
            r_ac2b6 <= 32'(32'(i_b5 - 32'sd4000) * 32'(i_cal.ac2));
            r_ac3b6 <= 32'(32'(i_b5 - 32'sd4000) * 32'(i_cal.ac3));
            r_upa <= i_up; r_ta <= n_tsat; r_ea <= i_err;

            r_sq     <= bpc_pkg::asr32(r_b6sq, 12);
            r_ac2b6b <= r_ac2b6; r_ac3b6b <= r_ac3b6;
            r_upb <= r_upa; r_tb <= r_ta; r_eb <= r_ea;

            r_b2sq   <= 32'(r_sq * 32'(i_cal.b2));
            r_b1sq   <= 32'(r_sq * 32'(i_cal.b1));
            r_ac2b6c <= r_ac2b6b; r_ac3b6c <= r_ac3b6b;
            r_upc <= r_upb; r_tc <= r_tb; r_ec <= r_eb;

            // truncating divide by 4: bias negatives by 3 before the floor shift
            r_b3  <= n_b3pre[31] ? 32'((n_b3pre + 32'sd3) >>> 2) : (n_b3pre >>> 2);
            r_x3p <= 32'(n_x3b + 32'sd32768);
            r_upd <= r_upc; r_td <= r_tc; r_ed <= r_ec;

            r_b4     <= 32'(n_b4w[31:0] >> 15);
            r_updiff <= 32'($signed({13'd0, r_upd}) - r_b3);
            r_te <= r_td; r_ee <= r_ed;

            r_b4f <= r_b4;
            r_b7  <= 32'(r_updiff * 32'(32'd50000 >> i_cal.oss));
            r_tf  <= r_te; r_ef <= r_ee | (r_b4 == 32'd0);
        end
    end

    always_comb begin
        n_hi   = r_b7[31];
        n_num  = n_hi ? r_b7 : {r_b7[30:0], 1'b0};
        n_tag  = {r_tf, r_ef, n_hi, 1'b0};
        n_dtag = '0;
        n_dtag[bpc_pkg::PressTagW-1:0] = n_tag;
    end

    logic                        w_dv;
    logic [31:0]                 w_q;
    logic [bpc_pkg::DivTagW-1:0] w_tag;

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vf),
        .i_num   (n_num),
        .i_den   (r_b4f),
        .i_tag   (n_dtag),
        .o_valid (w_dv),
        .o_quo   (w_q),
        .o_tag   (w_tag)
    );

    // correction pipeline
    logic r_vg, r_vh; logic [31:0] r_pg, r_ph; logic [31:0] r_pp;
    logic signed [31:0] r_m1, r_m2;
    logic signed [15:0] r_tg, r_th; logic r_eg, r_eh;
    logic [31:0] n_p;
    logic signed [31:0] n_corr;
    logic signed [33:0] n_fin;

    always_comb begin
        n_p    = w_tag[1] ? {w_q[30:0], 1'b0} : w_q;
        n_corr = bpc_pkg::asr32(32'(32'(bpc_pkg::asr32(r_m1, 16)
                 + bpc_pkg::asr32(r_m2, 16)) + 32'sd3791), 4);
        n_fin  = $signed({2'b0, r_ph}) + 34'(n_corr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0; r_vh <= 1'b0; o_valid <= 1'b0;
        end else if (i_en) begin
            r_vg <= w_dv; r_vh <= r_vg; o_valid <= r_vh;
        end
        if (i_en) begin
            r_pg <= n_p;
            r_pp <= 32'({8'd0, n_p[31:8]} * {8'd0, n_p[31:8]});
            r_tg <= w_tag[bpc_pkg::PressTagW-1 -: 16]; r_eg <= w_tag[2];

            r_ph <= r_pg;
            r_m1 <= 32'($signed(r_pp) * 32'sd3038);
            r_m2 <= 32'($signed(r_pg) * -32'sd7357);
            r_th <= r_tg; r_eh <= r_eg;

            o_err <= r_eh;
            if (r_eh) begin
                o_temp <= '0; o_press <= '0;
            end else begin
                o_temp  <= r_th;
                o_press <= (n_fin < 34'sd0) ? 20'd0 :
                           (n_fin > 34'sd1048575) ? 20'hfffff : n_fin[19:0];
            end
        end
    end
endmodule

[hdl/barometric_pressure_compensation_core.sv]
// Barometric temperature and pressure compensation core.
// Input stream: s_axis tdata = {raw_pressure[18:0], raw_temperature[15:0]}
//   padded to 40 bits. One word per clock can be accepted while s_axis_tready is high.
// Output stream: m_axis tdata = {divide_error, pressure_pa[19:0],
//   temperature_tenths[15:0]} padded to 40 bits.
// Calibration: i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only while idle, the core does not enforce this.
// The pipeline has 3 stages around a 32-stage radix-2 divider for the
// temperature divide, then 6 stages, a second 32-stage divider for the
// pressure divide and 3 correction stages, the last being the output register.
// Throughput is one word per clock; the single pipeline enable advances
// every stage at once and is low only when the output register is full
// and the receiver holds tready low. A stall freezes everything, so no
// word is lost or repeated.
// Reset clears all valid bits and loads calibration to zero, oversampling
// mode to 1.
module barometric_pressure_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // temperature_tenths, pressure_pa, divide_error
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    bpc_pkg::t_cal r_cal;
    logic w_en;
    logic w_tv; logic signed [31:0] w_b5; logic [18:0] w_up; logic w_te;
    logic signed [15:0] w_temp; logic [19:0] w_press; logic w_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= '0;
            r_cal.oss <= 2'd1;
        end else if (i_cfg_we) begin
            case (bpc_pkg::t_reg_idx'(i_cfg_idx))
                bpc_pkg::REG_AC1_AC2: {r_cal.ac1, r_cal.ac2} <= i_cfg_data;
                bpc_pkg::REG_AC3_AC4: {r_cal.ac3, r_cal.ac4} <= i_cfg_data;
                bpc_pkg::REG_AC5_AC6: {r_cal.ac5, r_cal.ac6} <= i_cfg_data;
                bpc_pkg::REG_B1_B2:   {r_cal.b1, r_cal.b2}   <= i_cfg_data;
                bpc_pkg::REG_MC_MD:   {r_cal.mc, r_cal.md}   <= i_cfg_data;
                bpc_pkg::REG_OSS:     r_cal.oss              <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    bpc_temp u_temp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (s_axis_tvalid), .i_ut (s_axis_tdata[15:0]),
        .i_up (s_axis_tdata[34:16]), .i_cal (r_cal),
        .o_valid (w_tv), .o_b5 (w_b5), .o_up (w_up), .o_err (w_te)
    );

    bpc_press u_press (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_tv), .i_b5 (w_b5), .i_up (w_up), .i_err (w_te), .i_cal (r_cal),
        .o_valid (m_axis_tvalid), .o_temp (w_temp), .o_press (w_press), .o_err (w_err)
    );

    assign m_axis_tdata = {3'd0, w_err, w_press, w_temp};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_err |-> w_temp == 16'sd0 && w_press == 20'd0)
        else $error("error word carries nonzero results");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

[dv/barometric_pressure_compensation_core_test.sv]
`timescale 1ns / 1ps

module barometric_pressure_compensation_core_test;

    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [19:0]        pres;
        logic               derr;
    } t_comp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    barometric_pressure_compensation_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    localparam int Latency = 76;
    localparam int CycleLimit = 400000;

    logic [31:0] cal_regs [0:4];
    logic [1:0]  cal_oss;
    t_sample     pending_samples [$];
    t_comp       expected_comps [$];
    int          n_errors;
    int          n_cycles;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    logic        in_acc;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] fl_shift(input logic signed [31:0] v, input int n);
        return v >>> n;
    endfunction

    // signed 32-bit divide truncating toward zero, wrapping on overflow
    function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        longint q;
        q = longint'(a) / longint'(b);
        return q[31:0];
    endfunction

    function automatic t_comp compensate(input t_sample s);
        t_comp r;
        logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
        logic signed [31:0] ac4, ac5, ac6;
        logic signed [31:0] x1, x2, x3, den, b5, b6, sq, b3, t, corr;
        logic [31:0] b4, b7, p, d;
        longint fin;
        ac1 = $signed(cal_regs[0][31:16]); ac2 = $signed(cal_regs[0][15:0]);
        ac3 = $signed(cal_regs[1][31:16]); ac4 = {16'd0, cal_regs[1][15:0]};
        ac5 = {16'd0, cal_regs[2][31:16]}; ac6 = {16'd0, cal_regs[2][15:0]};
        b1 = $signed(cal_regs[3][31:16]);  b2 = $signed(cal_regs[3][15:0]);
        mc = $signed(cal_regs[4][31:16]);  md = $signed(cal_regs[4][15:0]);
        r = '0;
        r.derr = 1'b1;
        x1 = fl_shift(($signed({16'd0, s.ut}) - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = tdiv(mc * 2048, den);
        b5 = x1 + x2;
        t = fl_shift(b5 + 8, 4);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        b6 = b5 - 4000;
        sq = fl_shift(b6 * b6, 12);
        x1 = fl_shift(b2 * sq, 11);
        x2 = fl_shift(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = tdiv(((ac1 * 4 + x3) <<< cal_oss) + 2, 4);
        x1 = fl_shift(ac3 * b6, 13);
        x2 = fl_shift(b1 * sq, 16);
        x3 = fl_shift(x1 + x2 + 2, 2);
        d = x3 + 32768;
        b4 = (ac4 * d) >> 15;
        if (b4 == 0) return r;
        b7 = ($signed({13'd0, s.up}) - b3) * (32'd50000 >> cal_oss);
        if (!b7[31]) p = (b7 * 2) / b4;
        else p = (b7 / b4) * 2;
        x1 = (p >> 8) * (p >> 8);
        x1 = fl_shift(x1 * 3038, 16);
        x2 = fl_shift(-32'sd7357 * $signed(p), 16);
        corr = fl_shift(x1 + x2 + 3791, 4);
        fin = longint'(p) + longint'(corr);
        if (fin < 0) fin = 0;
        if (fin > 1048575) fin = 1048575;
        r.temp = t[15:0];
        r.pres = fin[19:0];
        r.derr = 1'b0;
        return r;
    endfunction

    // driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc) begin
                expected_comps.push_back(compensate(pending_samples.pop_front()));
            end
            if (!(s_axis_tvalid && !in_acc)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, pending_samples[0].up, pending_samples[0].ut};
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(20, 0);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            stall_phase <= stall_phase + 1;
            case (stall_phase[7:6])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(3, 0) != 0);
                2'd2: m_axis_tready <= stall_phase[1] ^ stall_phase[3];
                default: m_axis_tready <= ($urandom_range(4, 0) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_comp got;
        t_comp want;
        n_cycles <= n_cycles + 1;
        in_acc <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[35:16], m_axis_tdata[36]};
            if (expected_comps.size() == 0) begin
                $error("unexpected word %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = expected_comps.pop_front();
                if (got.temp !== want.temp) begin
                    $error("temperature_tenths exp %0d got %0d", want.temp, got.temp);
                    n_errors++;
                end
                if (got.pres !== want.pres) begin
                    $error("pressure_pa exp %0d got %0d", want.pres, got.pres);
                    n_errors++;
                end
                if (got.derr !== want.derr) begin
                    $error("divide_error exp %0d got %0d", want.derr, got.derr);
                    n_errors++;
                end
            end
        end
        if (n_cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_cal(input bpc_pkg::t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == bpc_pkg::REG_OSS) cal_oss = val[1:0];
        else cal_regs[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_comps.size() > 0)
            @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [15:0] ut, input logic [18:0] up);
        t_sample s;
        s.ut = ut;
        s.up = up;
        pending_samples.push_back(s);
    endtask

    // typical factory calibration with small random spread
    task automatic load_typical(input logic [1:0] oss);
        write_cal(bpc_pkg::REG_AC1_AC2, {16'(408 + $urandom_range(200, 0) - 100),
                                         16'(-72 + $urandom_range(40, 0) - 20)});
        write_cal(bpc_pkg::REG_AC3_AC4, {16'(-14383 + $urandom_range(400, 0) - 200),
                                         16'(32741 + $urandom_range(400, 0) - 200)});
        write_cal(bpc_pkg::REG_AC5_AC6, {16'(32757 - $urandom_range(400, 0)),
                                         16'(23153 + $urandom_range(400, 0) - 200)});
        write_cal(bpc_pkg::REG_B1_B2, {16'd6190, 16'd4});
        write_cal(bpc_pkg::REG_MC_MD, {16'(-8711 + $urandom_range(200, 0) - 100),
                                       16'(2868 + $urandom_range(200, 0) - 100)});
        write_cal(bpc_pkg::REG_OSS, {30'd0, oss});
    endtask

    task automatic random_phase(input int n);
        repeat (n) begin
            if ($urandom_range(9, 0) != 0)
                add_sample(16'(27898 + $urandom_range(8000, 0) - 4000),
                           19'(($urandom_range(30000, 0) + 9000) << cal_oss));
            else
                add_sample(16'($urandom), 19'($urandom));
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bpc_pkg::REG_AC1_AC2;
        i_cfg_data = '0;
        n_errors = 0;
        n_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        in_acc = 1'b0;
        for (int i = 0; i < 5; i++) cal_regs[i] = '0;
        cal_oss = 2'd1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // reset calibration: all zero so every word is a divide error
        add_sample(16'd0, 19'd0);
        add_sample(16'hFFFF, 19'h7FFFF);
        drain();
        load_typical(2'd0);
        add_sample(16'd27898, 19'd23843);
        add_sample(16'd0, 19'd0);
        add_sample(16'hFFFF, 19'h7FFFF);
        add_sample(16'd0, 19'h7FFFF);
        add_sample(16'hFFFF, 19'd0);
        add_sample(16'h8000, 19'h40000);
        add_sample(16'd23153, 19'd30000);
        drain();
        // X1+MD zero: AC5 zero makes X1 zero, MD zero
        write_cal(bpc_pkg::REG_MC_MD, 32'h8000_0000);
        write_cal(bpc_pkg::REG_AC5_AC6, 32'h0000_FFFF);
        add_sample(16'd1234, 19'd5000);
        drain();
        // B4 zero: AC4 zero
        load_typical(2'd3);
        write_cal(bpc_pkg::REG_AC3_AC4, 32'h8000_0000);
        add_sample(16'd27898, 19'd23843);
        drain();
        // extreme coefficients, saturation of both outputs
        write_cal(bpc_pkg::REG_AC1_AC2, 32'h7FFF_8000);
        write_cal(bpc_pkg::REG_AC3_AC4, 32'h8000_FFFF);
        write_cal(bpc_pkg::REG_AC5_AC6, 32'hFFFF_0000);
        write_cal(bpc_pkg::REG_B1_B2, 32'h7FFF_8000);
        write_cal(bpc_pkg::REG_MC_MD, 32'h7FFF_0001);
        add_sample(16'hFFFF, 19'h7FFFF);
        add_sample(16'd0, 19'd0);
        add_sample(16'd1, 19'd1);
        drain();
        write_cal(bpc_pkg::REG_MC_MD, 32'h8000_7FFF);
        write_cal(bpc_pkg::REG_B1_B2, 32'h8000_7FFF);
        add_sample(16'hFFFF, 19'h7FFFF);
        add_sample(16'd0, 19'h3FFFF);
        drain();
        for (int m = 0; m < 4; m++) begin
            load_typical(2'(m));
            random_phase(170);
        end
        // fully random calibration
        for (int k = 0; k < 5; k++) begin
            write_cal(bpc_pkg::REG_AC1_AC2, $urandom);
            write_cal(bpc_pkg::REG_AC3_AC4, $urandom);
            write_cal(bpc_pkg::REG_AC5_AC6, $urandom);
            write_cal(bpc_pkg::REG_B1_B2, $urandom);
            write_cal(bpc_pkg::REG_MC_MD, $urandom);
            write_cal(bpc_pkg::REG_OSS, $urandom);
            repeat (50) add_sample(16'($urandom), 19'($urandom));
            drain();
        end
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
